// ----- hdl/vertical_multitap_line_filter_defines.svh -----
// Assertion macros shared by the line filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef VERTICAL_MULTITAP_LINE_FILTER_DEFINES_SVH
`define VERTICAL_MULTITAP_LINE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent on every clock outside reset
`define VMLF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent on the following clock
`define VMLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must never hold outside reset
`define VMLF_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`else

`define VMLF_ASSERT_IMPL(lbl, ante, cons, msg)
`define VMLF_ASSERT_NEXT(lbl, ante, cons, msg)
`define VMLF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- hdl/vmlf_pkg.sv -----
// Shared types, constants and helpers of the vertical line filter.
// No dependencies; used by the result queue and the top level.
package vmlf_pkg;

	localparam int LINE_MAX_DEF = 4096;

	localparam int COL_W   = 12;
	localparam int SMP_W   = 16;
	localparam int SUM_W   = 32;
	localparam int PIX_W   = 8;

	localparam logic [SUM_W-1:0] ROUND_BIAS = 32'h0004_0000;
	localparam int OUT_SHIFT = 19;

	// result queue: four entries, pointers wrap naturally
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [PIX_W-1:0] pixel;
	} result_t;

	// Conditional subtracts of m << k for k = k_hi down to k_lo.
	// Two calls (upper and lower half of the shifts) give v mod m.
	function automatic logic [COL_W-1:0] mod_reduce(input logic [COL_W-1:0] v,
			input int unsigned m, input int k_hi, input int k_lo);
		logic [COL_W-1:0] r;
		logic [31:0] step;
		r = v;
		for (int k = k_hi; k >= k_lo; k--) begin
			step = 32'(m) << k;
			if (32'(r) >= step)
				r = r - step[COL_W-1:0];
		end
		return r;
	endfunction

	// sum >> 19 clamped to 0..255; negative sums give zero
	function automatic logic [PIX_W-1:0] to_pixel(input logic [SUM_W-1:0] sum);
		logic [PIX_W-1:0] p;
		if (sum[SUM_W-1])
			p = '0;
		else if (|sum[SUM_W-2:OUT_SHIFT+PIX_W])
			p = '1;
		else
			p = sum[OUT_SHIFT+PIX_W-1:OUT_SHIFT];
		return p;
	endfunction

endpackage

// ----- hdl/vmlf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module vmlf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- hdl/vmlf_result_fifo.sv -----
// Four-entry queue holding finished pixels until the output side takes them.
// Depends on vmlf_pkg and the assertion macro header.
`include "vertical_multitap_line_filter_defines.svh"

module vmlf_result_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  vmlf_pkg::result_t           push_data,
	input  logic                        stall,
	output logic                        valid,
	output vmlf_pkg::result_t           head,
	output logic [vmlf_pkg::QCNT_W-1:0] count
);

	vmlf_pkg::result_t                 entry_q [vmlf_pkg::QDEPTH];
	logic [vmlf_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [vmlf_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [vmlf_pkg::QCNT_W-1:0]       count_q;
	logic                              pop;

	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];
	assign count = count_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`VMLF_ASSERT_NEVER(a_no_overflow, push && !pop && (count_q == vmlf_pkg::QCNT_W'(vmlf_pkg::QDEPTH)), "result queue overflow")
	`VMLF_ASSERT_NEVER(a_count_range, count_q > vmlf_pkg::QCNT_W'(vmlf_pkg::QDEPTH), "queue count beyond depth")
	`VMLF_ASSERT_NEXT(a_push_shows, push && (count_q == '0), valid && (head == $past(push_data)), "pushed pixel not at head")

endmodule

// ----- hdl/vertical_multitap_line_filter.sv -----
// Vertical multi-tap line filter. One request (column, sample, coefficient, tap flags) is
// taken per clock while sample_stall is low; the per-column 32-bit sums live in a
// LINE_MAX-deep synchronous RAM that is read in stage 1 and written back in stage 2, with the
// newest sum forwarded when consecutive requests hit the same column. A last-tap request
// passes through stage 1 and stage 2 and then leaves its pixel in a four-entry output
// queue, whose head drives the output. sample_stall rises only when the queue plus
// the last-tap requests still in the two stages would reach four, i.e. while the output side
// holds off. The sum store is not cleared at reset: every column must see a first tap before
// any other tap. Columns at or beyond LINE_MAX use the store entry column mod LINE_MAX.
// Depends on vmlf_pkg, vmlf_ram, vmlf_result_fifo and the assertion macro header.
`include "vertical_multitap_line_filter_defines.svh"

module vertical_multitap_line_filter #(
	parameter int LINE_MAX = vmlf_pkg::LINE_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [vmlf_pkg::COL_W-1:0]         column,
	input  logic signed [vmlf_pkg::SMP_W-1:0]  sample,
	input  logic signed [vmlf_pkg::SMP_W-1:0]  coefficient,
	input  logic                               first_tap,
	input  logic                               last_tap,
	output logic                               pixel_valid,
	input  logic                               pixel_stall,
	output logic [vmlf_pkg::COL_W-1:0]         out_column,
	output logic [vmlf_pkg::PIX_W-1:0]         pixel
);

	localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
	localparam int HALF  = vmlf_pkg::COL_W / 2;

	logic                              accept;

	// stage 1: product, partially reduced column, RAM read issued
	logic                              v_s1;
	logic [vmlf_pkg::COL_W-1:0]        col_s1;
	logic [vmlf_pkg::COL_W-1:0]        rem_s1;
	logic [vmlf_pkg::SUM_W-1:0]        prod_s1;
	logic                              first_s1;
	logic                              last_s1;
	logic [IDX_W-1:0]                  idx_s1;
	logic                              hit_s1;

	// stage 2: read data back, sum formed and written
	logic                              v_s2;
	logic [vmlf_pkg::COL_W-1:0]        col_s2;
	logic [IDX_W-1:0]                  idx_s2;
	logic [vmlf_pkg::SUM_W-1:0]        prod_s2;
	logic                              first_s2;
	logic                              last_s2;
	logic                              fwd_s2;
	logic [vmlf_pkg::SUM_W-1:0]        fwd_data_s2;
	logic [vmlf_pkg::SUM_W-1:0]        rdata_s2;
	logic [vmlf_pkg::SUM_W-1:0]        base_s2;
	logic [vmlf_pkg::SUM_W-1:0]        sum_s2;

	vmlf_pkg::result_t                 res_s2;
	vmlf_pkg::result_t                 head;
	logic [vmlf_pkg::QCNT_W-1:0]       q_count;
	logic [vmlf_pkg::QCNT_W-1:0]       pending;

	assign accept = sample_valid && !sample_stall;

	// reserve queue room for every last tap still in flight
	assign pending = q_count + vmlf_pkg::QCNT_W'(v_s1 && last_s1)
	               + vmlf_pkg::QCNT_W'(v_s2 && last_s2);
	assign sample_stall = (pending >= vmlf_pkg::QCNT_W'(vmlf_pkg::QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			fwd_s2 <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			fwd_s2 <= hit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= column;
			rem_s1   <= vmlf_pkg::mod_reduce(column, LINE_MAX, vmlf_pkg::COL_W - 1, HALF);
			prod_s1  <= vmlf_pkg::SUM_W'(sample * coefficient);
			first_s1 <= first_tap;
			last_s1  <= last_tap;
		end
		col_s2      <= col_s1;
		idx_s2      <= idx_s1;
		prod_s2     <= prod_s1;
		first_s2    <= first_s1;
		last_s2     <= last_s1;
		fwd_data_s2 <= sum_s2;
	end

	assign idx_s1 = IDX_W'(vmlf_pkg::mod_reduce(rem_s1, LINE_MAX, HALF - 1, 0));

	// the older item writes the same entry at the edge this read happens
	assign hit_s1 = v_s1 && v_s2 && (idx_s1 == idx_s2);

	vmlf_ram #(
		.WIDTH (vmlf_pkg::SUM_W),
		.DEPTH (LINE_MAX)
	) u_sums (
		.clk   (clk),
		.we    (v_s2),
		.waddr (idx_s2),
		.wdata (sum_s2),
		.re    (v_s1),
		.raddr (idx_s1),
		.rdata (rdata_s2)
	);

	always_comb begin
		if (first_s2)
			base_s2 = vmlf_pkg::ROUND_BIAS;
		else if (fwd_s2)
			base_s2 = fwd_data_s2;
		else
			base_s2 = rdata_s2;
		sum_s2 = base_s2 + prod_s2;
	end

	assign res_s2.column = col_s2;
	assign res_s2.pixel  = vmlf_pkg::to_pixel(sum_s2);

	vmlf_result_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2 && last_s2),
		.push_data (res_s2),
		.stall     (pixel_stall),
		.valid     (pixel_valid),
		.head      (head),
		.count     (q_count)
	);

	assign out_column = head.column;
	assign pixel      = head.pixel;

	`VMLF_ASSERT_NEVER(a_pending_fits, pending > vmlf_pkg::QCNT_W'(vmlf_pkg::QDEPTH), "in-flight results exceed queue room")
	`VMLF_ASSERT_IMPL(a_fwd_same_idx, v_s2 && fwd_s2, idx_s2 == $past(idx_s2), "forwarded sum from another entry")
	`VMLF_ASSERT_NEXT(a_fwd_needs_pair, hit_s1, v_s2 && $past(v_s2), "forward without an older write")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for vertical_multitap_line_filter: directed and random tap requests,
// a per-column sum predictor and an in-order pixel check. Depends on vmlf_pkg and the RTL.
module tb_top;
	import vmlf_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_TAPS  = 105;
	localparam int BURST_TAPS  = 24;
	localparam int MAX_OPEN    = 8;
	localparam int LONG_HOLD   = 150;
	localparam int SETTLE      = 20;
	localparam int PIXEL_CEIL  = (1 << PIX_W) - 1;

	typedef struct {
		logic [COL_W-1:0]        column;
		logic signed [SMP_W-1:0] sample;
		logic signed [SMP_W-1:0] coefficient;
		logic                    first_tap;
		logic                    last_tap;
	} tap_req_t;

	class pixel_scoreboard;
		bit [SUM_W-1:0] column_sums [LINE_MAX_DEF];
		result_t        expected_pixels [$];
		int             errors;

		function void note_request(tap_req_t r);
			int             product;
			int             idx;
			bit [SUM_W-1:0] total;
			bit [SUM_W-1:0] shifted;
			result_t        res;
			idx = r.column % LINE_MAX_DEF;
			product = int'(r.sample) * int'(r.coefficient);
			total = (r.first_tap ? ROUND_BIAS : column_sums[idx]) + 32'(product);
			column_sums[idx] = total;
			if (r.last_tap) begin
				shifted = total >> OUT_SHIFT;
				res.column = r.column;
				if (total[SUM_W-1])
					res.pixel = '0;
				else if (shifted > PIXEL_CEIL)
					res.pixel = '1;
				else
					res.pixel = shifted[PIX_W-1:0];
				expected_pixels.push_back(res);
			end
		endfunction

		function void check_pixel(logic [COL_W-1:0] col, logic [PIX_W-1:0] pix);
			result_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel %0d for column %0d with none expected", pix, col);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (col !== want.column) begin
					$error("out_column: expected %0d, got %0d", want.column, col);
					errors++;
				end
				if (pix !== want.pixel) begin
					$error("pixel: expected %0d, got %0d", want.pixel, pix);
					errors++;
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    sample_valid;
	logic                    sample_stall;
	logic [COL_W-1:0]        column;
	logic signed [SMP_W-1:0] sample;
	logic signed [SMP_W-1:0] coefficient;
	logic                    first_tap;
	logic                    last_tap;
	logic                    pixel_valid;
	logic                    pixel_stall;
	logic [COL_W-1:0]        out_column;
	logic [PIX_W-1:0]        pixel;

	pixel_scoreboard  pixel_board;
	logic [COL_W-1:0] open_cols [$];
	logic [COL_W-1:0] done_cols [$];
	int               max_send_gap;
	int               max_hold;
	bit               long_hold_req;
	int               idle_cycles;

	vertical_multitap_line_filter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.column       (column),
		.sample       (sample),
		.coefficient  (coefficient),
		.first_tap    (first_tap),
		.last_tap     (last_tap),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.out_column   (out_column),
		.pixel        (pixel)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic tap_req_t make_tap(int col, int s, int c, bit first, bit last);
		tap_req_t r;
		r.column      = COL_W'(col);
		r.sample      = SMP_W'(s);
		r.coefficient = SMP_W'(c);
		r.first_tap   = first;
		r.last_tap    = last;
		return r;
	endfunction

	function automatic tap_req_t random_operands(logic [COL_W-1:0] col, bit first, bit last);
		tap_req_t r;
		r.column    = col;
		r.first_tap = first;
		r.last_tap  = last;
		if ($urandom_range(0, 2) == 0) begin
			r.sample      = SMP_W'($urandom);
			r.coefficient = SMP_W'($urandom);
		end else begin
			// scaler-like: positive samples, weights around unity gain of 4096
			r.sample      = SMP_W'($urandom_range(0, 32767));
			r.coefficient = SMP_W'($urandom_range(0, 5000) - 700);
		end
		return r;
	endfunction

	// Mostly well-formed column sequences (first, middle taps, last) interleaved over a few
	// open columns; the rest restarts open columns or adds stray taps to finished ones.
	function automatic tap_req_t next_random_tap();
		tap_req_t         r;
		int               pick;
		int               slot;
		logic [COL_W-1:0] col;
		pick = $urandom_range(0, 99);
		if (open_cols.size() == 0 || (pick < 20 && open_cols.size() < MAX_OPEN)) begin
			case ($urandom_range(0, 5))
				0: col = '0;
				1: col = '1;
				2: col = COL_W'($urandom_range(0, 7));
				default: col = COL_W'($urandom_range(0, LINE_MAX_DEF - 1));
			endcase
			r = random_operands(col, 1'b1, $urandom_range(0, 9) == 0);
			if (r.last_tap)
				done_cols.push_back(col);
			else
				open_cols.push_back(col);
		end else if (pick < 90) begin
			// newest column often, so the same column comes back to back
			slot = (pick < 45) ? open_cols.size() - 1 : $urandom_range(0, open_cols.size() - 1);
			r = random_operands(open_cols[slot], 1'b0, $urandom_range(0, 3) == 0);
			if (r.last_tap) begin
				done_cols.push_back(open_cols[slot]);
				open_cols.delete(slot);
			end
		end else if (pick < 95 || done_cols.size() == 0) begin
			slot = $urandom_range(0, open_cols.size() - 1);
			r = random_operands(open_cols[slot], 1'b1, 1'b0);
		end else begin
			col = done_cols[$urandom_range(0, done_cols.size() - 1)];
			r = random_operands(col, 1'b0, $urandom_range(0, 1) == 1);
		end
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_tap(input tap_req_t r);
		int gap;
		gap = $urandom_range(0, max_send_gap);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		column       <= r.column;
		sample       <= r.sample;
		coefficient  <= r.coefficient;
		first_tap    <= r.first_tap;
		last_tap     <= r.last_tap;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		pixel_board.note_request(r);
		@(negedge clk);
	endtask

	// drop the request so the last one is not taken again while waiting
	task automatic drain_pixels();
		sample_valid <= 1'b0;
		do
			@(negedge clk);
		while (pixel_board.expected_pixels.size() != 0);
	endtask

	task automatic random_phase(input int send_gap, input int hold);
		max_send_gap = send_gap;
		max_hold     = hold;
		repeat (PHASE_TAPS)
			send_tap(next_random_tap());
	endtask

	initial begin : pixel_sink
		int hold;
		pixel_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold = $urandom_range(0, max_hold);
			end
			if (hold > 0) begin
				pixel_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				pixel_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (!pixel_valid);
			pixel_board.check_pixel(out_column, pixel);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (pixel_valid && !pixel_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		pixel_board   = new();
		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		column        = '0;
		sample        = '0;
		coefficient   = '0;
		first_tap     = 1'b0;
		last_tap      = 1'b0;
		max_send_gap  = 0;
		max_hold      = 0;
		long_hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, back to back so same-column requests hit the forwarding path
		send_tap(make_tap(0, 32767, 32767, 1, 1));
		send_tap(make_tap(4095, -32768, 32767, 1, 1));
		send_tap(make_tap(2048, 0, 0, 1, 1));
		// four products of 2^30 wrap the sum back to the bias
		send_tap(make_tap(1, -32768, -32768, 1, 0));
		repeat (3)
			send_tap(make_tap(1, -32768, -32768, 0, 0));
		send_tap(make_tap(1, 32767, 2048, 0, 1));
		// sum lands exactly on 255, then one step past it
		send_tap(make_tap(7, 8144, 16384, 1, 1));
		send_tap(make_tap(8, 8176, 16384, 1, 1));
		send_tap(make_tap(5, 1000, 3000, 1, 0));
		send_tap(make_tap(6, -2000, 1500, 1, 0));
		send_tap(make_tap(5, 20000, 2000, 0, 0));
		send_tap(make_tap(6, 30000, 4000, 0, 1));
		send_tap(make_tap(5, 32767, -1, 0, 1));
		// restart a finished column, then a stray tap on another finished one
		send_tap(make_tap(0, 100, 200, 1, 0));
		send_tap(make_tap(0, -32768, -32768, 0, 1));
		send_tap(make_tap(4095, 12345, 1000, 0, 1));
		drain_pixels();

		random_phase(18, 18);

		// output side holds off while last-tap requests keep coming
		max_send_gap  = 0;
		long_hold_req = 1'b1;
		repeat (BURST_TAPS)
			send_tap(random_operands(COL_W'($urandom_range(0, LINE_MAX_DEF - 1)), 1'b1, 1'b1));
		drain_pixels();

		random_phase(0, 0);
		random_phase(0, 18);
		random_phase(18, 0);

		drain_pixels();
		repeat (SETTLE) @(posedge clk);
		if (pixel_board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/vmlf_pkg.sv
hdl/vmlf_ram.sv
hdl/vmlf_result_fifo.sv
hdl/vertical_multitap_line_filter.sv
tb/tb_top.sv
